// File: rtl/ssla_pkg.sv
`default_nettype none

package ssla_pkg;

  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned FRAC_BITS   = SAMPLE_BITS + 4;
  localparam int unsigned XW          = FRAC_BITS + 2;
  localparam int unsigned ACC_W       = SAMPLE_BITS + 8;
  localparam int unsigned SUM_W       = ACC_W + 2;
  localparam int unsigned MA_W        = SUM_W;
  localparam int unsigned K_W         = 26;
  localparam int unsigned MP_W        = MA_W + K_W;
  localparam int unsigned YW          = ACC_W + 4;
  localparam int unsigned THR_W       = 23;
  localparam int unsigned Q_SHIFT     = 24;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic REG_THRESHOLD = 1'b0;

  localparam logic [THR_W-1:0] THRESH_RESET = 23'd4194304;

  localparam logic signed [K_W-1:0] TWEAK_K = 26'sd694935;
  localparam logic signed [K_W-1:0] DECAY_K = 26'sd15367353;
  localparam logic signed [K_W-1:0] GAIN_K  = 26'sd22857243;

  typedef enum logic [3:0] {
    ST_TWEAK,
    ST_HALF,
    ST_DEC_A1,
    ST_DEC_B1,
    ST_PICK1,
    ST_DEC_A2,
    ST_DEC_B2,
    ST_ADD_B2,
    ST_PICK2,
    ST_SUM,
    ST_GAIN,
    ST_OUT
  } step_e;

  typedef struct packed {
    logic  load;
    logic  adv;
    step_e step;
  } lane_ctrl_t;

  function automatic step_e next_step(input step_e s);
    step_e n;
    case (s)
      ST_TWEAK:  n = ST_HALF;
      ST_HALF:   n = ST_DEC_A1;
      ST_DEC_A1: n = ST_DEC_B1;
      ST_DEC_B1: n = ST_PICK1;
      ST_PICK1:  n = ST_DEC_A2;
      ST_DEC_A2: n = ST_DEC_B2;
      ST_DEC_B2: n = ST_ADD_B2;
      ST_ADD_B2: n = ST_PICK2;
      ST_PICK2:  n = ST_SUM;
      ST_SUM:    n = ST_GAIN;
      ST_GAIN:   n = ST_OUT;
      default:   n = ST_TWEAK;
    endcase
    return n;
  endfunction

  function automatic logic signed [MP_W-1:0] rnd_q24(input logic signed [MP_W-1:0] p);
    logic signed [MP_W-1:0] half_lsb;
    half_lsb = MP_W'(1) <<< (Q_SHIFT - 1);
    return (p + half_lsb) >>> Q_SHIFT;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [YW-1:0] v);
    logic signed [YW-1:0] hi;
    logic signed [YW-1:0] lo;
    logic signed [SAMPLE_BITS-1:0] r;
    hi = (YW'(1) <<< (SAMPLE_BITS - 1)) - YW'(1);
    lo = ~hi;
    if (v > hi) begin
      r = hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      r = lo[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ssla_lane.sv
`default_nettype none

module ssla_lane (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire ssla_pkg::lane_ctrl_t                  ctrl_i,
  input  wire logic [ssla_pkg::THR_W-1:0]            thr_i,
  input  wire logic signed [ssla_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic signed [ssla_pkg::SAMPLE_BITS-1:0]    y_o
);
  import ssla_pkg::*;

  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic signed [SAMPLE_BITS-1:0] h0_q, h1_q, h2_q;
  logic signed [XW-1:0]          half_q, half_d;
  logic signed [ACC_W-1:0]       d_q, d_d;
  logic signed [ACC_W-1:0]       acc_a_q, acc_b_q;
  logic                          phase_q;
  logic signed [ACC_W-1:0]       prev_q, hdiff_q;
  logic signed [SUM_W-1:0]       sum_q, sum_d;
  logic signed [MP_W-1:0]        prod_q, prod_d;

  logic signed [MA_W-1:0]        mul_a;
  logic signed [K_W-1:0]         mul_k;
  logic signed [SAMPLE_BITS:0]   hist_diff;
  logic signed [MP_W-1:0]        rp;
  logic signed [ACC_W-1:0]       rp_acc;
  logic signed [XW-1:0]          x_ext, h0_ext, thr_x, lim;
  logic [THR_W+FRAC_BITS-1:0]    thr_wide;
  logic signed [ACC_W:0]         acc_a_sum, acc_b_sum, d_ext;
  logic signed [ACC_W:0]         full_rnd;
  logic signed [YW-1:0]          y_full, y_rnd;

  assign hist_diff = (SAMPLE_BITS+1)'(h2_q) - (SAMPLE_BITS+1)'(h1_q);
  assign x_ext     = XW'($signed({smp_q, 4'b0}));
  assign h0_ext    = XW'($signed({h0_q, 4'b0}));
  assign thr_wide  = {thr_i, FRAC_BITS'(0)} >> THR_W;
  assign thr_x     = $signed(XW'(thr_wide));

  always_comb begin
    mul_a = '0;
    mul_k = DECAY_K;
    case (ctrl_i.step)
      ST_TWEAK: begin
        mul_a = MA_W'($signed({hist_diff, 4'b0}));
        mul_k = TWEAK_K;
      end
      ST_HALF, ST_DEC_A2: mul_a = MA_W'(acc_a_q);
      ST_DEC_A1, ST_DEC_B2: mul_a = MA_W'(acc_b_q);
      ST_PICK1, ST_PICK2: mul_a = phase_q ? MA_W'(acc_a_q) : MA_W'(acc_b_q);
      ST_GAIN: begin
        mul_a = MA_W'(sum_q);
        mul_k = GAIN_K;
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_k;
  assign rp     = rnd_q24(prod_q);
  assign rp_acc = rp[ACC_W-1:0];

  assign half_d = (x_ext + h0_ext + XW'(rp) + XW'(1)) >>> 1;

  always_comb begin
    if (x_ext - half_q > thr_x) begin
      lim = half_q + thr_x;
    end else if (half_q - x_ext > thr_x) begin
      lim = half_q - thr_x;
    end else begin
      lim = x_ext;
    end
  end

  assign d_d       = ACC_W'(lim) - ACC_W'(x_ext);
  assign d_ext     = (ACC_W+1)'(d_q);
  assign acc_a_sum = phase_q ? (ACC_W+1)'(rp_acc) + d_ext : (ACC_W+1)'(rp_acc) - d_ext;
  assign acc_b_sum = phase_q ? (ACC_W+1)'(rp_acc) - d_ext : (ACC_W+1)'(rp_acc) + d_ext;
  assign full_rnd  = (ACC_W+1)'(rp_acc) + (ACC_W+1)'(1);
  assign sum_d     = SUM_W'(rp_acc) + SUM_W'(hdiff_q) + SUM_W'(prev_q);

  assign y_full = YW'(x_ext) + YW'(rp);
  assign y_rnd  = (y_full + YW'(8)) >>> 4;
  assign y_o    = sat_sample(y_rnd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h0_q    <= '0;
      h1_q    <= '0;
      h2_q    <= '0;
      acc_a_q <= '0;
      acc_b_q <= '0;
      phase_q <= 1'b0;
      prev_q  <= '0;
    end else if (ctrl_i.adv) begin
      case (ctrl_i.step)
        ST_HALF: begin
          h2_q <= h1_q;
          h1_q <= h0_q;
          h0_q <= smp_q;
        end
        ST_DEC_A1: acc_a_q <= rp_acc;
        ST_DEC_B1: acc_b_q <= rp_acc;
        ST_PICK1, ST_PICK2: phase_q <= ~phase_q;
        ST_DEC_B2: acc_a_q <= sat_acc(acc_a_sum);
        ST_ADD_B2: acc_b_q <= sat_acc(acc_b_sum);
        ST_SUM: prev_q <= full_rnd[ACC_W:1];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      smp_q <= sample_i;
    end
    if (ctrl_i.adv) begin
      prod_q <= prod_d;
      case (ctrl_i.step)
        ST_HALF:   half_q  <= half_d;
        ST_DEC_B1: d_q     <= d_d;
        ST_DEC_A2: hdiff_q <= rp_acc;
        ST_SUM:    sum_q   <= sum_d;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/ssla_merge.sv
`default_nettype none

module ssla_merge (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    load_i,
  input  wire logic signed [ssla_pkg::SAMPLE_BITS-1:0] left_i,
  input  wire logic signed [ssla_pkg::SAMPLE_BITS-1:0] right_i,
  output logic                                         load_ready_o,
  output logic                                         out_valid_o,
  input  wire logic                                    out_ready_i,
  output logic signed [ssla_pkg::SAMPLE_BITS-1:0]      left_out_o,
  output logic signed [ssla_pkg::SAMPLE_BITS-1:0]      right_out_o
);
  import ssla_pkg::*;

  logic                          valid_q;
  logic signed [SAMPLE_BITS-1:0] left_q, right_q;

  assign load_ready_o = !valid_q || out_ready_i;
  assign out_valid_o  = valid_q;
  assign left_out_o   = left_q;
  assign right_out_o  = right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i && load_ready_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && load_ready_o) begin
      left_q  <= left_i;
      right_q <= right_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/stereo_slew_limiter_antialiased.sv
`default_nettype none

// Stereo slew-rate limiter with half-sample antialiasing. Each item is one stereo frame;
// the left and right channels run in two identical lanes with their own history and
// accumulators, and their results land together in one output register. Each lane owns a
// single constant multiplier that it steps through twelve steps (tweak, half-way sample,
// four accumulator decays, one accumulator add, two picks, sum, gain, output); a new frame
// is taken only once the lanes have left their output step, and a full output register
// that is not being drained stalls the lanes at their last step. The slew threshold register
// (byte address 0) resets to 0.5 and should be written only while the block is idle.
module stereo_slew_limiter_antialiased (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    psel,
  input  wire logic                                    penable,
  input  wire logic                                    pwrite,
  input  wire logic [ssla_pkg::ADDR_W-1:0]             paddr,
  input  wire logic [ssla_pkg::DATA_W-1:0]             pwdata,
  output logic [ssla_pkg::DATA_W-1:0]                  prdata,
  output logic                                         pready,
  input  wire logic                                    in_valid_i,
  output logic                                         in_ready_o,
  input  wire logic signed [ssla_pkg::SAMPLE_BITS-1:0] left_sample_i,
  input  wire logic signed [ssla_pkg::SAMPLE_BITS-1:0] right_sample_i,
  output logic                                         out_valid_o,
  input  wire logic                                    out_ready_i,
  output logic signed [ssla_pkg::SAMPLE_BITS-1:0]      left_out_o,
  output logic signed [ssla_pkg::SAMPLE_BITS-1:0]      right_out_o
);
  import ssla_pkg::*;

  logic [THR_W-1:0]              thr_q;
  logic                          busy_q;
  step_e                         step_q;
  logic                          load_ready;
  logic                          advance;
  logic                          reg_hit;
  lane_ctrl_t                    lane_ctrl;
  logic signed [SAMPLE_BITS-1:0] left_y, right_y;

  assign pready  = 1'b1;
  assign reg_hit = paddr[ADDR_W-1] == REG_THRESHOLD;
  assign prdata  = reg_hit ? DATA_W'(thr_q) : '0;

  assign in_ready_o = !busy_q;
  assign advance    = busy_q && ((step_q != ST_OUT) || load_ready);

  assign lane_ctrl.load = in_valid_i && in_ready_o;
  assign lane_ctrl.adv  = advance;
  assign lane_ctrl.step = step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THRESH_RESET;
      busy_q <= 1'b0;
      step_q <= ST_TWEAK;
    end else begin
      if (psel && penable && pwrite && pready && reg_hit) begin
        thr_q <= pwdata[THR_W-1:0];
      end
      if (lane_ctrl.load) begin
        busy_q <= 1'b1;
        step_q <= ST_TWEAK;
      end else if (advance) begin
        if (step_q == ST_OUT) begin
          busy_q <= 1'b0;
        end
        step_q <= next_step(step_q);
      end
    end
  end

  ssla_lane u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .thr_i    (thr_q),
    .sample_i (left_sample_i),
    .y_o      (left_y)
  );

  ssla_lane u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .thr_i    (thr_q),
    .sample_i (right_sample_i),
    .y_o      (right_y)
  );

  ssla_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (busy_q && (step_q == ST_OUT)),
    .left_i       (left_y),
    .right_i      (right_y),
    .load_ready_o (load_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .left_out_o   (left_out_o),
    .right_out_o  (right_out_o)
  );

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> busy_q && (step_q == ST_TWEAK))
    else $error("accepted item did not start the lanes");

  a_result_from_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(busy_q && (step_q == ST_OUT)))
    else $error("result registered without lanes at output step");

  a_done_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(step_q) == ST_OUT)
    else $error("lanes went idle before output step");
`endif

endmodule

`default_nettype wire

// File: sim/slew_frame_checker.sv
module slew_frame_checker (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    psel_i,
  input  logic                                    penable_i,
  input  logic                                    pwrite_i,
  input  logic                                    pready_i,
  input  logic [ssla_pkg::ADDR_W-1:0]             paddr_i,
  input  logic [ssla_pkg::DATA_W-1:0]             pwdata_i,
  input  logic                                    in_valid_i,
  input  logic                                    in_ready_i,
  input  logic signed [ssla_pkg::SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [ssla_pkg::SAMPLE_BITS-1:0] right_sample_i,
  input  logic                                    out_valid_i,
  input  logic                                    out_ready_i,
  input  logic signed [ssla_pkg::SAMPLE_BITS-1:0] left_out_i,
  input  logic signed [ssla_pkg::SAMPLE_BITS-1:0] right_out_i,
  output int                                      fail_count_o,
  output int                                      outstanding_o
);
  import ssla_pkg::*;

  localparam logic [ADDR_W-1:0] THRESHOLD_ADDR     = ADDR_W'(REG_THRESHOLD) << 2;
  localparam logic [THR_W-1:0]  THRESHOLD_AT_RESET = 23'd4194304;
  localparam longint            TWEAK_Q24          = 694935;
  localparam longint            DECAY_Q24          = 15367353;
  localparam longint            GAIN_Q24           = 22857243;
  localparam int                ACC_BITS           = SAMPLE_BITS + 8;
  localparam int                INT_FRAC           = SAMPLE_BITS + 4;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } frame_t;

  frame_t           expected_frames [$];
  frame_t           want;
  int               errors;
  logic [THR_W-1:0] threshold;
  longint           hist [2][3];
  longint           acc_a [2];
  longint           acc_b [2];
  bit               accum_phase [2];
  longint           prev_half_diff [2];

  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint saturate(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint decay_accums(input int ch, input longint d);
    longint pick;
    acc_a[ch] = saturate(round_shift(acc_a[ch] * DECAY_Q24, 24), ACC_BITS);
    acc_b[ch] = saturate(round_shift(acc_b[ch] * DECAY_Q24, 24), ACC_BITS);
    if (accum_phase[ch]) begin
      acc_a[ch] = saturate(acc_a[ch] + d, ACC_BITS);
      acc_b[ch] = saturate(acc_b[ch] - d, ACC_BITS);
      pick = acc_a[ch];
    end else begin
      acc_b[ch] = saturate(acc_b[ch] + d, ACC_BITS);
      acc_a[ch] = saturate(acc_a[ch] - d, ACC_BITS);
      pick = acc_b[ch];
    end
    accum_phase[ch] = !accum_phase[ch];
    return round_shift(pick * DECAY_Q24, 24);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] predict_lane(
    input int ch, input logic signed [SAMPLE_BITS-1:0] raw);
    longint x;
    longint thr;
    longint tw;
    longint half;
    longint lim;
    longint half_diff;
    longint full_diff;
    longint sum;
    longint y;
    x = longint'(raw) * 16;
    thr = (longint'(threshold) << INT_FRAC) >> THR_W;
    tw = round_shift((hist[ch][2] - hist[ch][1]) * 16 * TWEAK_Q24, 24);
    half = round_shift(x + hist[ch][0] * 16 + tw, 1);
    hist[ch][2] = hist[ch][1];
    hist[ch][1] = hist[ch][0];
    hist[ch][0] = longint'(raw);
    half_diff = decay_accums(ch, 0);
    lim = x;
    if (x - half > thr) begin
      lim = half + thr;
    end else if (half - x > thr) begin
      lim = half - thr;
    end
    full_diff = decay_accums(ch, lim - x);
    sum = full_diff + half_diff + prev_half_diff[ch];
    prev_half_diff[ch] = round_shift(full_diff, 1);
    y = x + round_shift(sum * GAIN_Q24, 24);
    y = saturate(round_shift(y, 4), SAMPLE_BITS);
    return y[SAMPLE_BITS-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int ch = 0; ch < 2; ch++) begin
        for (int k = 0; k < 3; k++) hist[ch][k] = 0;
        acc_a[ch] = 0;
        acc_b[ch] = 0;
        accum_phase[ch] = 1'b0;
        prev_half_diff[ch] = 0;
      end
      threshold = THRESHOLD_AT_RESET;
      expected_frames.delete();
      errors = 0;
      fail_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == THRESHOLD_ADDR) begin
        threshold = pwdata_i[THR_W-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_frames.size() == 0) begin
          $error("result item with no frame pending: left_out %0d, right_out %0d",
                 left_out_i, right_out_i);
          errors++;
        end else begin
          want = expected_frames.pop_front();
          if (left_out_i !== want.left) begin
            $error("left_out: expected %0d, got %0d", want.left, left_out_i);
            errors++;
          end
          if (right_out_i !== want.right) begin
            $error("right_out: expected %0d, got %0d", want.right, right_out_i);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        want.left = predict_lane(0, left_sample_i);
        want.right = predict_lane(1, right_sample_i);
        expected_frames.push_back(want);
      end
      fail_count_o <= errors;
      outstanding_o <= expected_frames.size();
    end
  end

endmodule

// File: sim/tb_top.sv
module tb_top;
  import ssla_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [ADDR_W-1:0] THRESHOLD_ADDR = ADDR_W'(REG_THRESHOLD) << 2;
  localparam int FRAMES_PER_SETTING = 200;
  localparam int THRESHOLD_SETTINGS = 9;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [ADDR_W-1:0]             paddr;
  logic [DATA_W-1:0]             pwdata;
  logic [DATA_W-1:0]             prdata;
  logic                          pready;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic signed [SAMPLE_BITS-1:0] left_sample_i;
  logic signed [SAMPLE_BITS-1:0] right_sample_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic signed [SAMPLE_BITS-1:0] left_out_o;
  logic signed [SAMPLE_BITS-1:0] right_out_o;

  int                            send_idle_pct;
  int                            recv_idle_pct;
  int                            fail_count;
  int                            outstanding;
  logic signed [SAMPLE_BITS-1:0] walk_left;
  logic signed [SAMPLE_BITS-1:0] walk_right;
  logic [THR_W-1:0]              thr;

  stereo_slew_limiter_antialiased uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o)
  );

  slew_frame_checker checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_out_i     (left_out_o),
    .right_out_i    (right_out_o),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #8000000;
    $display("tb_top: done, errors");
    $finish;
  end

  task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] l,
                            input logic signed [SAMPLE_BITS-1:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_sample_i <= l;
    right_sample_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= THRESHOLD_ADDR;
    pwdata <= DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] next_sample(
    input logic signed [SAMPLE_BITS-1:0] prev);
    int unsigned kind;
    int          span;
    kind = $urandom_range(9);
    span = 256 << (5 * $urandom_range(3));
    if (kind < 3) return SAMPLE_BITS'($urandom);
    if (kind == 3) return $urandom_range(1) ? S_MAX : S_MIN;
    return prev + SAMPLE_BITS'(int'($urandom_range(2 * span)) - span);
  endfunction

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    left_sample_i = '0;
    right_sample_i = '0;
    send_idle_pct = 15;
    recv_idle_pct = 52;
    walk_left = '0;
    walk_right = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    repeat (3) send_frame('0, '0);
    send_frame(S_MAX, S_MAX);
    send_frame(S_MIN, S_MIN);
    for (int i = 0; i < 8; i++) begin
      send_frame(i[0] ? S_MAX : S_MIN, i[0] ? S_MIN : S_MAX);
    end
    send_frame(24'sd1, -24'sd1);
    send_frame(-24'sd1, 24'sd1);
    send_frame(24'h555555, 24'hAAAAAA);
    send_frame(24'hAAAAAA, 24'h555555);
    repeat (3) send_frame('0, '0);

    for (int setting = 0; setting < THRESHOLD_SETTINGS; setting++) begin
      if (setting == 3) begin
        send_idle_pct = 52;
        recv_idle_pct = 15;
      end
      if (setting == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (setting > 0) begin
        case (setting)
          1:       thr = '0;
          2:       thr = '1;
          3:       thr = THR_W'(1);
          4, 6:    thr = THR_W'($urandom_range(4095));
          7:       thr = THR_W'($urandom_range(255));
          default: thr = THR_W'($urandom);
        endcase
        in_valid_i <= 1'b0;
        wait_idle();
        write_threshold(thr);
      end
      for (int n = 0; n < FRAMES_PER_SETTING; n++) begin
        walk_left = next_sample(walk_left);
        walk_right = next_sample(walk_right);
        send_frame(walk_left, walk_right);
      end
    end

    in_valid_i <= 1'b0;
    wait_idle();
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ssla_pkg.sv
rtl/ssla_lane.sv
rtl/ssla_merge.sv
rtl/stereo_slew_limiter_antialiased.sv
sim/slew_frame_checker.sv
sim/tb_top.sv
